// ----- src/oghd_pkg.sv -----
package oghd_pkg;

    // Field widths of the item and result channels
    localparam int MODE_W   = 2;
    localparam int COORD_W  = 11;
    localparam int HITS_W   = 8;
    localparam int TAG_W    = 3;
    localparam int CLASS_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Grid size default
    localparam int GRID_SIZE_DEF = 128;

    // Saturation limit of a hit counter
    localparam logic [HITS_W-1:0] HIT_MAX = 8'd255;

    // Command modes
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DECAY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAINT_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRONG_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_CLASS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAINT_CLASS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRONG_CLASS = 3'd4;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] FAINT_THR_RST    = 8'd2;
    localparam logic [CFG_DATA_W-1:0] STRONG_THR_RST   = 8'd6;
    localparam logic [CFG_DATA_W-1:0] EMPTY_CLASS_RST  = 8'd0;
    localparam logic [CFG_DATA_W-1:0] FAINT_CLASS_RST  = 8'd80;
    localparam logic [CFG_DATA_W-1:0] STRONG_CLASS_RST = 8'd200;

    // One memory word: tag and hit count of a cell
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [HITS_W-1:0] hits;
    } cell_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_SWEEP_END,
        ST_LOOKUP,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // latch the item and read its cell
        logic cnt_clr;    // return the cell counter to zero
        logic cnt_inc;    // advance the cell counter
        logic clear_wr;   // write zero at the cell counter
        logic sweep_rd;   // read at the cell counter for decay
        logic lookup_rd;  // read the latched cell again
        logic finish;     // write back an update and load the result
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cnt_last;   // cell counter at the last cell
        logic out_free;   // result register can take a new result
        logic in_decay;   // offered item is a decay
    } status_t;

endpackage

// ----- src/occupancy_grid_hit_decay.sv -----
// Occupancy grid of GRID_SIZE x GRID_SIZE cells, each an 8-bit hit count and a
// 3-bit source tag, held in one memory with a registered read port. After reset
// a clearing pass writes every cell to zero, one per cycle, so s_ready stays low
// until the pass ends; configuration writes are taken during that pass. An update
// or a read first reads the cell; then an in-range update writes the new count
// back, and both load the result. A decay walks the whole memory with one read
// and one write per cycle and then reads the addressed cell again for its result.
// A finished result waits in the output register; the next transfer is accepted
// meanwhile and stalls in its last cycle only while that register is occupied and m_ready is low.
module occupancy_grid_hit_decay
    import oghd_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [MODE_W-1:0]          s_mode,
    input  logic signed [COORD_W-1:0]  s_col,
    input  logic signed [COORD_W-1:0]  s_row,
    input  logic [HITS_W-1:0]          s_weight,
    input  logic [TAG_W-1:0]           s_source,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [CLASS_W-1:0]         m_cell_class,
    output logic [TAG_W-1:0]           m_cell_tag,
    output logic [HITS_W-1:0]          m_cell_hits,
    output logic                       m_in_range
);

    cmd_t    cmd;
    status_t status;

    oghd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    oghd_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_mode       (s_mode),
        .s_col        (s_col),
        .s_row        (s_row),
        .s_weight     (s_weight),
        .s_source     (s_source),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_class (m_cell_class),
        .m_cell_tag   (m_cell_tag),
        .m_cell_hits  (m_cell_hits),
        .m_in_range   (m_in_range)
    );

endmodule

// ----- src/oghd_ctrl.sv -----
module oghd_ctrl
    import oghd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign take = s_valid && (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.cnt_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (take) state_next = status.in_decay ? ST_SWEEP : ST_FINISH;
            end
            ST_SWEEP: begin
                if (status.cnt_last) state_next = ST_SWEEP_END;
            end
            ST_SWEEP_END: state_next = ST_LOOKUP;
            ST_LOOKUP:    state_next = ST_FINISH;
            ST_FINISH: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                cmd.cnt_inc  = 1'b1;
                cmd.cnt_clr  = status.cnt_last;
            end
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = take;
            end
            ST_SWEEP: begin
                cmd.sweep_rd = 1'b1;
                cmd.cnt_inc  = 1'b1;
                cmd.cnt_clr  = status.cnt_last;
            end
            ST_SWEEP_END: ;
            ST_LOOKUP: cmd.lookup_rd = 1'b1;
            ST_FINISH: cmd.finish    = status.out_free;
            default: ;
        endcase
    end

endmodule

// ----- src/oghd_datapath.sv -----
module oghd_datapath
    import oghd_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic [MODE_W-1:0]          s_mode,
    input  logic signed [COORD_W-1:0]  s_col,
    input  logic signed [COORD_W-1:0]  s_row,
    input  logic [HITS_W-1:0]          s_weight,
    input  logic [TAG_W-1:0]           s_source,
    input  cmd_t                       cmd,
    output status_t                    status,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [CLASS_W-1:0]         m_cell_class,
    output logic [TAG_W-1:0]           m_cell_tag,
    output logic [HITS_W-1:0]          m_cell_hits,
    output logic                       m_in_range
);

    localparam int CellCount = GRID_SIZE * GRID_SIZE;
    localparam int AddrW     = $clog2(CellCount);
    localparam int CoordW    = $clog2(GRID_SIZE);

    // Configuration registers
    logic [CFG_DATA_W-1:0] faint_thr_reg;
    logic [CFG_DATA_W-1:0] strong_thr_reg;
    logic [CFG_DATA_W-1:0] empty_class_reg;
    logic [CFG_DATA_W-1:0] faint_class_reg;
    logic [CFG_DATA_W-1:0] strong_class_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            faint_thr_reg    <= FAINT_THR_RST;
            strong_thr_reg   <= STRONG_THR_RST;
            empty_class_reg  <= EMPTY_CLASS_RST;
            faint_class_reg  <= FAINT_CLASS_RST;
            strong_class_reg <= STRONG_CLASS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FAINT_THR:    faint_thr_reg    <= cfg_wr_data;
                CFG_STRONG_THR:   strong_thr_reg   <= cfg_wr_data;
                CFG_EMPTY_CLASS:  empty_class_reg  <= cfg_wr_data;
                CFG_FAINT_CLASS:  faint_class_reg  <= cfg_wr_data;
                CFG_STRONG_CLASS: strong_class_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Range check and cell address of the offered item
    logic             in_ok;
    logic [AddrW-1:0] in_addr;

    assign in_ok = !s_col[COORD_W-1] && !s_row[COORD_W-1]
                && ({1'b0, s_col[COORD_W-2:0]} < COORD_W'(GRID_SIZE))
                && ({1'b0, s_row[COORD_W-2:0]} < COORD_W'(GRID_SIZE));
    assign in_addr = in_ok
        ? AddrW'(AddrW'(s_row[CoordW-1:0]) * AddrW'(GRID_SIZE)) + AddrW'(s_col[CoordW-1:0])
        : '0;

    // Latched item
    logic [AddrW-1:0]  addr_reg;
    logic              ok_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [HITS_W-1:0] weight_reg;
    logic [TAG_W-1:0]  source_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            addr_reg   <= in_addr;
            ok_reg     <= in_ok;
            mode_reg   <= s_mode;
            weight_reg <= s_weight;
            source_reg <= s_source;
        end
    end

    // Shared cell counter for the clearing pass and the decay sweep
    logic [AddrW-1:0] cnt_reg;
    logic [AddrW-1:0] cnt_next;

    always_comb begin
        priority if (cmd.cnt_clr) cnt_next = '0;
        else if (cmd.cnt_inc)     cnt_next = cnt_reg + 1'b1;
        else                      cnt_next = cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Decay write-back stage, in the cycle after the sweep read
    logic             wb_valid_reg;
    logic [AddrW-1:0] wb_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_valid_reg <= 1'b0;
        end else begin
            wb_valid_reg <= cmd.sweep_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sweep_rd) wb_addr_reg <= cnt_reg;
    end

    // Cell memory
    cell_t            cell_mem_reg [CellCount];
    cell_t            rd_data_reg;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    cell_t            wr_data;

    always_comb begin
        rd_en = cmd.accept || cmd.sweep_rd || cmd.lookup_rd;
        priority if (cmd.accept) rd_addr = in_addr;
        else if (cmd.sweep_rd)   rd_addr = cnt_reg;
        else                     rd_addr = addr_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) cell_mem_reg[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= cell_mem_reg[rd_addr];
    end

    // Decayed cell: a zero count drops the tag, otherwise count down
    cell_t decayed;

    always_comb begin
        if (rd_data_reg.hits == '0) begin
            decayed = '0;
        end else begin
            decayed.hits = rd_data_reg.hits - 1'b1;
            decayed.tag  = rd_data_reg.tag;
        end
    end

    // Updated cell: saturating add, nonzero source replaces the tag
    logic [HITS_W:0] sum;
    cell_t           updated;
    logic            do_update;
    cell_t           final_cell;

    assign sum          = {1'b0, rd_data_reg.hits} + {1'b0, weight_reg};
    assign updated.hits = sum[HITS_W] ? HIT_MAX : sum[HITS_W-1:0];
    assign updated.tag  = (source_reg != '0) ? source_reg : rd_data_reg.tag;
    assign do_update    = ok_reg && (mode_reg == MODE_UPDATE);
    assign final_cell   = do_update ? updated : rd_data_reg;

    // Memory write select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = updated;
        priority if (cmd.clear_wr) begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg;
            wr_data = '0;
        end else if (wb_valid_reg) begin
            wr_en   = 1'b1;
            wr_addr = wb_addr_reg;
            wr_data = decayed;
        end else if (cmd.finish && do_update) begin
            wr_en = 1'b1;
        end
    end

    // Class of the final count
    logic [CLASS_W-1:0] cls;

    always_comb begin
        priority if (final_cell.hits >= strong_thr_reg) cls = strong_class_reg;
        else if (final_cell.hits >= faint_thr_reg)      cls = faint_class_reg;
        else                                            cls = empty_class_reg;
    end

    // Result register
    logic m_valid_reg;
    logic m_valid_next;

    assign m_valid_next = cmd.finish ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    logic [CLASS_W-1:0] class_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [HITS_W-1:0]  hits_reg;
    logic               range_reg;

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            class_reg <= ok_reg ? cls : '0;
            tag_reg   <= ok_reg ? final_cell.tag : '0;
            hits_reg  <= ok_reg ? final_cell.hits : '0;
            range_reg <= ok_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_class = class_reg;
    assign m_cell_tag   = tag_reg;
    assign m_cell_hits  = hits_reg;
    assign m_in_range   = range_reg;

    // Status
    assign status.cnt_last = (cnt_reg == AddrW'(CellCount - 1));
    assign status.out_free = !m_valid_reg || m_ready;
    assign status.in_decay = (s_mode == MODE_DECAY);

endmodule

// ----- src/oghd_checker.sv -----
module oghd_assertions
    import oghd_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [CLASS_W-1:0] m_cell_class,
    input logic [TAG_W-1:0]   m_cell_tag,
    input logic [HITS_W-1:0]  m_cell_hits,
    input logic               m_in_range
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_hits) && $stable(m_cell_tag)
            && $stable(m_cell_class) && $stable(m_in_range))
        else $error("stalled result changed");

    // Drop ready for the clearing pass after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("ready during clearing pass");

    // One item at a time: ready drops after each transfer
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer taken while busy");

    // Zero payload for coordinates outside the grid
    a_out_of_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_range |-> m_cell_hits == '0 && m_cell_tag == '0
            && m_cell_class == '0)
        else $error("nonzero payload outside the grid");

endmodule

bind occupancy_grid_hit_decay oghd_assertions u_oghd_assertions (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_cell_class (m_cell_class),
    .m_cell_tag   (m_cell_tag),
    .m_cell_hits  (m_cell_hits),
    .m_in_range   (m_in_range)
);
